// ===== src/ser_pkg.sv =====
// Shared types and constants for the switch event recorder.
// No dependencies; ser_core, ser_outbuf and switch_event_recorder refer to it by scoped names.
`default_nettype none
package ser_pkg;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_RECORD = 2'd1,
		MODE_UPLOAD = 2'd2
	} mode_t;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_HOST   = 2'd2;

	localparam logic [1:0] ID_WITH    = 2'd1;
	localparam logic [1:0] ID_THROW   = 2'd2;
	localparam logic [1:0] ID_WITHOUT = 2'd3;

	localparam logic [7:0] OVF_FLAG       = 8'h20;
	localparam logic [7:0] HOLD_MAX       = 8'hFF;
	localparam logic [7:0] LONG_PRESS_RST = 8'd5;
	localparam int         SEC_W          = 16;
	localparam int         ADDR_W         = 13;
	localparam int         USED_W         = 14;

	typedef struct packed {
		logic [1:0] opcode;
		logic       with_pressed;
		logic       throw_pressed;
		logic       without_pressed;
	} item_t;

	typedef struct packed {
		logic              write_valid;
		logic [ADDR_W-1:0] write_addr;
		logic [7:0]        write_byte;
		logic [1:0]        mode;
		logic              led_on;
		logic [7:0]        session;
		logic [USED_W-1:0] entries_used;
		logic              last;
	} result_t;

	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} res_pair_t;

endpackage
`default_nettype wire

// ===== src/ser_in_if.sv =====
// Input channel of the switch event recorder: valid/ready and one item.
// No dependencies.
`default_nettype none
interface ser_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic       with_pressed;
	logic       throw_pressed;
	logic       without_pressed;

	modport source (output valid, opcode, with_pressed, throw_pressed, without_pressed,
		input ready);
	modport sink (input valid, opcode, with_pressed, throw_pressed, without_pressed,
		output ready);
endinterface
`default_nettype wire

// ===== src/ser_out_if.sv =====
// Result channel of the switch event recorder: valid/ready and one result.
// No dependencies.
`default_nettype none
interface ser_out_if;
	logic        valid;
	logic        ready;
	logic        write_valid;
	logic [12:0] write_addr;
	logic [7:0]  write_byte;
	logic [1:0]  mode;
	logic        led_on;
	logic [7:0]  session;
	logic [13:0] entries_used;
	logic        last;

	modport source (output valid, write_valid, write_addr, write_byte, mode, led_on,
		session, entries_used, last, input ready);
	modport sink (input valid, write_valid, write_addr, write_byte, mode, led_on,
		session, entries_used, last, output ready);
endinterface
`default_nettype wire

// ===== src/ser_core.sv =====
// Recorder state registers and the single-pass next-state and result logic.
// Depends on ser_pkg.
`default_nettype none
module ser_core #(
	parameter int LOG_BYTES  = 8192,
	parameter int DELTA_BITS = 5
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   step,
	input  ser_pkg::item_t        item,
	input  wire  [7:0]            long_press,
	output ser_pkg::res_pair_t    res
);
	localparam int ECW = $clog2(LOG_BYTES + 1);
	localparam logic [ECW-1:0] LOG_LIM = ECW'(LOG_BYTES);
	localparam logic [ser_pkg::SEC_W-1:0] DMASK = ser_pkg::SEC_W'((1 << DELTA_BITS) - 1);

	ser_pkg::mode_t                mode_q, mode_d;
	logic                          er_q, er_d;
	logic [1:0]                    sid_q, sid_d;
	logic                          led_q, led_d;
	logic                          hs_q, hs_d;
	logic [7:0]                    hsec_q, hsec_d;
	logic [ser_pkg::SEC_W-1:0]     now_q, now_d;
	logic [ser_pkg::SEC_W-1:0]     prev_q, prev_d;
	logic [7:0]                    sess_q, sess_d;
	logic [ECW-1:0]                ec_q, ec_d;

	logic [1:0]                    nsel;
	logic                          do_log;
	logic [ser_pkg::SEC_W-1:0]     delta;
	logic                          big;
	logic [ECW-1:0]                ec_p1;
	logic                          ok0, ok1;
	logic [7:0]                    byte0, byte1;
	logic [31:0]                   a0_w, a1_w, used_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ser_pkg::MODE_IDLE;
			er_q   <= 1'b0;
			sid_q  <= 2'd0;
			led_q  <= 1'b0;
			hs_q   <= 1'b0;
			hsec_q <= 8'd0;
			now_q  <= '0;
			prev_q <= '0;
			sess_q <= 8'd0;
			ec_q   <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			er_q   <= er_d;
			sid_q  <= sid_d;
			led_q  <= led_d;
			hs_q   <= hs_d;
			hsec_q <= hsec_d;
			now_q  <= now_d;
			prev_q <= prev_d;
			sess_q <= sess_d;
			ec_q   <= ec_d;
		end
	end

	assign nsel  = {1'b0, item.with_pressed} + {1'b0, item.throw_pressed}
		+ {1'b0, item.without_pressed};
	assign delta = now_q - prev_q;
	assign big   = delta > DMASK;
	assign ec_p1 = ec_q + ECW'(1);
	assign byte0 = {sid_q, 6'd0} | (big ? ser_pkg::OVF_FLAG : 8'd0) | 8'(delta & DMASK);
	assign byte1 = 8'(delta >> DELTA_BITS);

	always_comb begin
		mode_d = mode_q;
		er_d   = er_q;
		sid_d  = sid_q;
		led_d  = led_q;
		hs_d   = hs_q;
		hsec_d = hsec_q;
		now_d  = now_q;
		prev_d = prev_q;
		sess_d = sess_q;
		ec_d   = ec_q;
		do_log = 1'b0;
		case (item.opcode)
			ser_pkg::OP_SAMPLE: begin
				if (nsel == 2'd1) begin
					if (!er_q) begin
						sid_d = item.with_pressed ? ser_pkg::ID_WITH :
							(item.without_pressed ? ser_pkg::ID_WITHOUT : ser_pkg::ID_THROW);
						if (mode_q == ser_pkg::MODE_RECORD) begin
							er_d   = 1'b1;
							led_d  = 1'b1;
							hs_d   = 1'b0;
							hsec_d = 8'd0;
						end
					end else if (sid_q == ser_pkg::ID_THROW && led_q) begin
						if (!hs_q) begin
							hs_d   = 1'b1;
							hsec_d = 8'd0;
						end else if (hsec_q >= long_press) begin
							mode_d = ser_pkg::MODE_UPLOAD;
							hsec_d = 8'd0;
							hs_d   = 1'b0;
							led_d  = 1'b0;
							er_d   = 1'b0;
						end
					end else begin
						hs_d   = 1'b0;
						hsec_d = 8'd0;
					end
				end else if (nsel == 2'd0) begin
					led_d = 1'b0;
					if (mode_q == ser_pkg::MODE_RECORD && er_q) begin
						do_log = 1'b1;
						prev_d = now_q;
						er_d   = 1'b0;
					end
				end
				if (mode_q == ser_pkg::MODE_IDLE && item.throw_pressed) begin
					sess_d = sess_q + 8'd1;
					now_d  = '0;
					prev_d = '0;
					hsec_d = 8'd0;
					mode_d = ser_pkg::MODE_RECORD;
				end
			end
			ser_pkg::OP_TICK: begin
				now_d = now_q + ser_pkg::SEC_W'(1);
				if (hs_q && hsec_q != ser_pkg::HOLD_MAX)
					hsec_d = hsec_q + 8'd1;
			end
			ser_pkg::OP_HOST: begin
				if (mode_q == ser_pkg::MODE_UPLOAD)
					mode_d = ser_pkg::MODE_IDLE;
			end
			default: begin
			end
		endcase
		ok0 = do_log && (ec_q < LOG_LIM);
		ok1 = ok0 && big && (ec_p1 < LOG_LIM);
		if (ok1)
			ec_d = ec_q + ECW'(2);
		else if (ok0)
			ec_d = ec_p1;
	end

	assign a0_w   = 32'(ec_q);
	assign a1_w   = 32'(ec_p1);
	assign used_w = 32'(ec_d);

	always_comb begin
		res.two             = ok1;
		res.r0.write_valid  = ok0;
		res.r0.write_addr   = ok0 ? a0_w[ser_pkg::ADDR_W-1:0] : '0;
		res.r0.write_byte   = ok0 ? byte0 : 8'd0;
		res.r0.mode         = mode_d;
		res.r0.led_on       = led_d;
		res.r0.session      = sess_d;
		res.r0.entries_used = used_w[ser_pkg::USED_W-1:0];
		res.r0.last         = !ok1;
		res.r1              = res.r0;
		res.r1.write_valid  = 1'b1;
		res.r1.write_addr   = a1_w[ser_pkg::ADDR_W-1:0];
		res.r1.write_byte   = byte1;
		res.r1.last         = 1'b1;
	end
endmodule
`default_nettype wire

// ===== src/ser_outbuf.sv =====
// Result register: holds one or two results of an item and hands them out in order.
// Depends on ser_pkg and ser_out_if.
`default_nettype none
module ser_outbuf (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 load,
	input  ser_pkg::res_pair_t  res,
	output logic                free,
	ser_out_if.source           out_ch
);
	logic [1:0]       rem_q;
	logic             hd_q;
	ser_pkg::result_t res0_q, res1_q, cur;
	logic             take;

	assign take = out_ch.valid && out_ch.ready;
	assign free = (rem_q == 2'd0) || (rem_q == 2'd1 && out_ch.ready);
	assign cur  = hd_q ? res1_q : res0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
			hd_q  <= 1'b0;
		end else if (load) begin
			rem_q <= res.two ? 2'd2 : 2'd1;
			hd_q  <= 1'b0;
		end else if (take) begin
			rem_q <= rem_q - 2'd1;
			hd_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res0_q <= res.r0;
			res1_q <= res.r1;
		end
	end

	assign out_ch.valid        = rem_q != 2'd0;
	assign out_ch.write_valid  = cur.write_valid;
	assign out_ch.write_addr   = cur.write_addr;
	assign out_ch.write_byte   = cur.write_byte;
	assign out_ch.mode         = cur.mode;
	assign out_ch.led_on       = cur.led_on;
	assign out_ch.session      = cur.session;
	assign out_ch.entries_used = cur.entries_used;
	assign out_ch.last         = cur.last;
endmodule
`default_nettype wire

// ===== src/switch_event_recorder.sv =====
// Switch event recorder top level: input register, recorder core, result register.
// An input transaction passes the input register, then the core logic, then the result register.
// Throughput: one item per cycle while the result receiver is ready; an item that logs two bytes
// holds the result register until both of its result transactions are taken.
// Reset (arst_n low): idle mode, all counters zero, hold time register back to 5.
// Depends on ser_pkg, ser_in_if, ser_out_if, ser_core and ser_outbuf.
`default_nettype none
module switch_event_recorder #(
	parameter int LOG_BYTES  = 8192,
	parameter int DELTA_BITS = 5
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire  [7:0] cfg_wdata,
	ser_in_if.sink     in_ch,
	ser_out_if.source  out_ch
);
	logic               valid_s1;
	ser_pkg::item_t     item_s1;
	logic [7:0]         long_press_q;
	logic               free;
	logic               step;
	ser_pkg::res_pair_t res;

	assign step        = valid_s1 && free;
	assign in_ch.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			long_press_q <= ser_pkg::LONG_PRESS_RST;
		end else begin
			if (in_ch.valid && in_ch.ready)
				valid_s1 <= 1'b1;
			else if (step)
				valid_s1 <= 1'b0;
			if (cfg_we)
				long_press_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.opcode          <= in_ch.opcode;
			item_s1.with_pressed    <= in_ch.with_pressed;
			item_s1.throw_pressed   <= in_ch.throw_pressed;
			item_s1.without_pressed <= in_ch.without_pressed;
		end
	end

	ser_core #(
		.LOG_BYTES  (LOG_BYTES),
		.DELTA_BITS (DELTA_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.item       (item_s1),
		.long_press (long_press_q),
		.res        (res)
	);

	ser_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step),
		.res    (res),
		.free   (free),
		.out_ch (out_ch)
	);
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for switch_event_recorder: randomized sessions, presses, holds and ticks
// against an in-bench predictor, with bursty input and a stalling result receiver.
// Depends on src/ser_pkg.sv, src/ser_in_if.sv, src/ser_out_if.sv and the recorder RTL.
`default_nettype none
module tb_top;

	localparam int         LOG_BYTES  = 8192;
	localparam int         DELTA_BITS = 5;
	localparam logic [7:0] DELTA_MASK = 8'((1 << DELTA_BITS) - 1);
	localparam logic [1:0] OP_NOP     = 2'd3;
	localparam int         SETTLE     = 8;
	localparam int         LIMIT      = 600000;

	class ser_scoreboard;
		ser_pkg::mode_t   mode;
		logic             ev_ready;
		logic [1:0]       sw_id;
		logic             led;
		logic             hold_on;
		logic [7:0]       hold_secs;
		logic [15:0]      sec_now;
		logic [15:0]      sec_prev;
		logic [7:0]       session;
		int               entries;
		logic [7:0]       long_press;
		logic [12:0]      addr_q[$];
		logic [7:0]       byte_q[$];
		ser_pkg::result_t expected_q[$];
		int               errors, checked, stored, dropped, uploads, sessions;

		function new();
			mode       = ser_pkg::MODE_IDLE;
			ev_ready   = 1'b0;
			sw_id      = '0;
			led        = 1'b0;
			hold_on    = 1'b0;
			hold_secs  = '0;
			sec_now    = '0;
			sec_prev   = '0;
			session    = '0;
			entries    = 0;
			long_press = ser_pkg::LONG_PRESS_RST;
		endfunction

		function void set_long_press(logic [7:0] v);
			long_press = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void store(logic [7:0] b);
			if (entries < LOG_BYTES && addr_q.size() < 2) begin
				addr_q.push_back(entries[12:0]);
				byte_q.push_back(b);
				entries++;
				stored++;
			end else begin
				dropped++;
			end
		endfunction

		function void log_event();
			logic [15:0] delta;
			logic [7:0]  head;
			delta    = sec_now - sec_prev;
			head     = {sw_id, 6'd0};
			sec_prev = sec_now;
			if (delta <= DELTA_MASK) begin
				store(head | delta[7:0]);
			end else begin
				store(head | ser_pkg::OVF_FLAG | (delta[7:0] & DELTA_MASK));
				store(8'(delta >> DELTA_BITS));
			end
			ev_ready = 1'b0;
		endfunction

		function void apply_switches(logic w, logic t, logic o);
			int n;
			n = int'(w) + int'(t) + int'(o);
			if (n >= 2)
				return;
			if (n == 1) begin
				if (!ev_ready) begin
					sw_id = w ? ser_pkg::ID_WITH : (o ? ser_pkg::ID_WITHOUT : ser_pkg::ID_THROW);
					if (mode == ser_pkg::MODE_RECORD) begin
						ev_ready  = 1'b1;
						led       = 1'b1;
						hold_on   = 1'b0;
						hold_secs = '0;
					end
				end else if (sw_id == ser_pkg::ID_THROW && led) begin
					if (!hold_on) begin
						hold_on   = 1'b1;
						hold_secs = '0;
					end else if (hold_secs >= long_press) begin
						mode      = ser_pkg::MODE_UPLOAD;
						hold_secs = '0;
						hold_on   = 1'b0;
						led       = 1'b0;
						ev_ready  = 1'b0;
						uploads++;
					end
				end else begin
					hold_on   = 1'b0;
					hold_secs = '0;
				end
			end else begin
				led = 1'b0;
				if (mode == ser_pkg::MODE_RECORD && ev_ready)
					log_event();
			end
		endfunction

		function void note_item(ser_pkg::item_t it);
			ser_pkg::mode_t   was;
			ser_pkg::result_t r;
			int               n, cnt, k;
			addr_q.delete();
			byte_q.delete();
			case (it.opcode)
				ser_pkg::OP_SAMPLE: begin
					was = mode;
					apply_switches(it.with_pressed, it.throw_pressed, it.without_pressed);
					if (was == ser_pkg::MODE_IDLE && it.throw_pressed) begin
						session++;
						sec_now   = '0;
						sec_prev  = '0;
						hold_secs = '0;
						mode      = ser_pkg::MODE_RECORD;
						sessions++;
					end
				end
				ser_pkg::OP_TICK: begin
					sec_now++;
					if (hold_on && hold_secs < ser_pkg::HOLD_MAX)
						hold_secs++;
				end
				ser_pkg::OP_HOST: begin
					if (mode == ser_pkg::MODE_UPLOAD)
						mode = ser_pkg::MODE_IDLE;
				end
				default: ;
			endcase
			n   = addr_q.size();
			cnt = (n > 0) ? n : 1;
			for (k = 0; k < cnt; k++) begin
				r.write_valid  = k < n;
				r.write_addr   = (k < n) ? addr_q[k] : '0;
				r.write_byte   = (k < n) ? byte_q[k] : '0;
				r.mode         = mode;
				r.led_on       = led;
				r.session      = session;
				r.entries_used = entries[13:0];
				r.last         = k == cnt - 1;
				expected_q.push_back(r);
			end
		endfunction

		function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(ser_pkg::result_t got);
			ser_pkg::result_t want;
			checked++;
			if (expected_q.size() == 0) begin
				$error("result transaction with nothing pending: write_valid %0d addr %0d byte %0h",
					got.write_valid, got.write_addr, got.write_byte);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			cmp_field("write_valid", want.write_valid, got.write_valid);
			cmp_field("write_addr", want.write_addr, got.write_addr);
			cmp_field("write_byte", want.write_byte, got.write_byte);
			cmp_field("mode", want.mode, got.mode);
			cmp_field("led_on", want.led_on, got.led_on);
			cmp_field("session", want.session, got.session);
			cmp_field("entries_used", want.entries_used, got.entries_used);
			cmp_field("last", want.last, got.last);
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [7:0]  cfg_wdata = '0;
	logic        rx_ready  = 1'b0;
	logic [31:0] rx_pattern = '1;
	logic [5:0]  rx_phase  = '0;
	int          cycles    = 0;
	int          items_sent = 0;
	int          burst_left = 0;
	int          settings_used = 1;
	ser_scoreboard sb;

	ser_in_if  in_ch();
	ser_out_if out_ch();

	assign out_ch.ready = rx_ready;

	switch_event_recorder #(
		.LOG_BYTES(LOG_BYTES),
		.DELTA_BITS(DELTA_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("switch_event_recorder verification failed");
			$finish;
		end
	end

	// result side: check each accepted transaction, then stall on a rotating pattern
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(ser_pkg::result_t'({out_ch.write_valid, out_ch.write_addr,
				out_ch.write_byte, out_ch.mode, out_ch.led_on, out_ch.session,
				out_ch.entries_used, out_ch.last}));
		if (rx_phase == '1)
			rx_pattern <= ($urandom_range(0, 3) == 0) ? '1 : $urandom;
		rx_phase <= rx_phase + 1'b1;
		rx_ready <= rx_pattern[rx_phase[4:0]];
	end

	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic ser_pkg::item_t mk(logic [1:0] op, logic w, logic t, logic o);
		ser_pkg::item_t it;
		it.opcode          = op;
		it.with_pressed    = w;
		it.throw_pressed   = t;
		it.without_pressed = o;
		return it;
	endfunction

	function automatic ser_pkg::item_t press(logic [1:0] id);
		return mk(ser_pkg::OP_SAMPLE, id == ser_pkg::ID_WITH, id == ser_pkg::ID_THROW,
			id == ser_pkg::ID_WITHOUT);
	endfunction

	function automatic ser_pkg::item_t all_up();
		return mk(ser_pkg::OP_SAMPLE, 1'b0, 1'b0, 1'b0);
	endfunction

	function automatic ser_pkg::item_t tick();
		return mk(ser_pkg::OP_TICK, coin(), coin(), coin());
	endfunction

	function automatic ser_pkg::item_t noise();
		return mk(2'($urandom_range(0, 3)), coin(), coin(), coin());
	endfunction

	task automatic push_item(ser_pkg::item_t it);
		in_ch.valid           <= 1'b1;
		in_ch.opcode          <= it.opcode;
		in_ch.with_pressed    <= it.with_pressed;
		in_ch.throw_pressed   <= it.throw_pressed;
		in_ch.without_pressed <= it.without_pressed;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_item(it);
		items_sent++;
	endtask

	task automatic send(ser_pkg::item_t it);
		push_item(it);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
		end
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_hold_time(logic [7:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_long_press(v);
		settings_used++;
	endtask

	task automatic event_seq();
		logic [1:0] id;
		int         n, r;
		id = 2'($urandom_range(1, 3));
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) send(tick());
		send(press(id));
		repeat ($urandom_range(0, 2))
			send(coin() ? press(id) : press(2'($urandom_range(1, 3))));
		r = $urandom_range(0, 9);
		if (r < 5)
			n = $urandom_range(0, 4);
		else if (r < 9)
			n = $urandom_range(28, 40);
		else
			n = $urandom_range(60, 100);
		repeat (n) send(tick());
		send(all_up());
	endtask

	task automatic hold_seq();
		int n;
		send(press(ser_pkg::ID_THROW));
		send(press(ser_pkg::ID_THROW));
		if (sb.long_press > 8 && $urandom_range(0, 3) != 0)
			n = $urandom_range(0, 6);
		else
			n = int'(sb.long_press) + int'($urandom_range(0, 45)) - 3;
		if (n < 0)
			n = 0;
		repeat (n) begin
			send(tick());
			if ($urandom_range(0, 7) == 0)
				send(press(ser_pkg::ID_THROW));
		end
		send(press(ser_pkg::ID_THROW));
		if (coin())
			send(all_up());
	endtask

	task automatic run_random(int count);
		int target, r;
		target = items_sent + count;
		while (items_sent < target) begin
			r = $urandom_range(0, 9);
			case (sb.mode)
				ser_pkg::MODE_UPLOAD: begin
					if (r < 3)
						send(noise());
					else
						send(mk(ser_pkg::OP_HOST, coin(), coin(), coin()));
				end
				ser_pkg::MODE_IDLE: begin
					if (r < 6)
						send(mk(ser_pkg::OP_SAMPLE, coin(), 1'b1, coin()));
					else if (r < 8)
						send(noise());
					else
						send(tick());
				end
				default: begin
					if (r < 5)
						event_seq();
					else if (r < 7)
						hold_seq();
					else if (r == 7)
						send(mk(ser_pkg::OP_SAMPLE, 1'b1, coin(), 1'b1));
					else if (r == 8)
						send(noise());
					else
						repeat ($urandom_range(1, 5)) send(tick());
				end
			endcase
		end
	endtask

	initial begin
		in_ch.valid           <= 1'b0;
		in_ch.opcode          <= ser_pkg::OP_SAMPLE;
		in_ch.with_pressed    <= 1'b0;
		in_ch.throw_pressed   <= 1'b0;
		in_ch.without_pressed <= 1'b0;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(mk(ser_pkg::OP_HOST, 1'b0, 1'b0, 1'b0));
		send(mk(OP_NOP, 1'b1, 1'b1, 1'b1));
		send(mk(ser_pkg::OP_TICK, 1'b0, 1'b0, 1'b0));
		send(press(ser_pkg::ID_WITH));
		send(all_up());
		send(mk(ser_pkg::OP_SAMPLE, 1'b1, 1'b1, 1'b0));
		send(all_up());
		send(mk(ser_pkg::OP_SAMPLE, 1'b1, 1'b1, 1'b1));
		send(press(ser_pkg::ID_WITHOUT));
		send(press(ser_pkg::ID_WITH));
		repeat (3) send(mk(ser_pkg::OP_TICK, 1'b1, 1'b1, 1'b1));
		send(all_up());
		send(press(ser_pkg::ID_THROW));
		send(press(ser_pkg::ID_THROW));
		repeat (5) send(tick());
		send(press(ser_pkg::ID_THROW));
		send(tick());
		send(press(ser_pkg::ID_WITH));
		send(mk(ser_pkg::OP_HOST, 1'b1, 1'b0, 1'b1));

		run_random(150);
		write_hold_time(8'd0);
		run_random(100);
		write_hold_time(8'd255);
		run_random(100);
		write_hold_time(8'd1);
		run_random(100);
		write_hold_time(8'($urandom_range(2, 254)));
		run_random(50);
		settle();
		run_random(50);
		write_hold_time(8'd5);
		run_random(30);

		settle();
		repeat (10) @(posedge clk);
		$display("Run: %0d input and %0d result transactions, %0d hold-time settings, %0d sessions.",
			items_sent, sb.checked, settings_used, sb.sessions);
		$display("Log: %0d bytes stored, %0d dropped, %0d long presses into upload.",
			sb.stored, sb.dropped, sb.uploads);
		if (sb.errors == 0)
			$display("switch_event_recorder verification clean");
		else
			$display("switch_event_recorder verification failed");
		$finish;
	end
endmodule
`default_nettype wire
